// ----- rtl/core/ptbl_pkg.sv -----
// package for the per-client token bucket limiter
// table size, config register indices, status codes, table entry type and divider control and status structs
// no dependencies
package ptbl_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int MS_PER_S  = 1000;
  localparam int DEN_W     = 26;
  localparam int QUO_W     = 17;
  localparam int QCNT_W    = 5;
  localparam int PROD_W    = 64;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 8'd1;

  typedef enum logic [1:0] {
    ST_ADMITTED = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_FULL     = 2'd2,
    ST_SWEEP    = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] tokens;
    logic [47:0] last_ms;
  } entry_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic             done;
    logic             sat;
    logic [QUO_W-1:0] quo;
  } div_sts_t;

endpackage

// ----- rtl/core/ptbl_ifs.sv -----
// channel interfaces of the token bucket limiter: items in, results out, config writes
// depends on ptbl_pkg
interface ptbl_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] client_key;
  logic [47:0] now_ms;
  modport source (output valid, command, client_key, now_ms, input ready);
  modport sink (input valid, command, client_key, now_ms, output ready);
endinterface

interface ptbl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] tokens_left;
  modport source (output valid, status, tokens_left, input ready);
  modport sink (input valid, status, tokens_left, output ready);
endinterface

interface ptbl_cfg_if import ptbl_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ptbl_div.sv -----
// restoring divider for the refill amount, one quotient bit a cycle
// flags a quotient of 2^17 or more as saturated; depends on ptbl_pkg
module ptbl_div import ptbl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctl_t          ctl,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DEN_W-1:0]  divisor,
  output div_sts_t          sts
);

  logic                     busy_r, busy_nxt;
  logic [PROD_W-1:0]        rem_r, rem_nxt;
  logic [DEN_W+QUO_W-1:0]   ds_r, ds_nxt;
  logic [QCNT_W-1:0]        cnt_r, cnt_nxt;
  logic [QUO_W-1:0]         quo_r, quo_nxt;
  logic                     sat_r, sat_nxt;
  logic                     done_r, done_nxt;
  logic                     ge;

  assign ge = rem_r >= PROD_W'(ds_r);

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    ds_nxt   = ds_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    sat_nxt  = sat_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = dividend;
      ds_nxt   = {divisor, QUO_W'(0)};
      cnt_nxt  = QCNT_W'(QUO_W);
      quo_nxt  = '0;
      sat_nxt  = 1'b0;
    end else if (busy_r) begin
      if (cnt_r == QCNT_W'(QUO_W)) begin
        if (ge) begin
          sat_nxt  = 1'b1;
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end else if (ge) begin
        rem_nxt = rem_r - PROD_W'(ds_r);
        quo_nxt = quo_r | (QUO_W'(1) << cnt_r);
      end
      ds_nxt  = ds_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    ds_r  <= ds_nxt;
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    sat_r <= sat_nxt;
  end

  assign sts.done = done_r;
  assign sts.sat  = sat_r;
  assign sts.quo  = quo_r;

endmodule

// ----- rtl/core/per_client_token_bucket_limiter.sv -----
// top level of the per-client token bucket limiter: table, scan sequencer, sweep
// depends on ptbl_pkg, ptbl_ifs and ptbl_div
//
// channel   direction  accepted when           payload
// in_ch     in         valid && ready          command, client_key, now_ms
// out_ch    out        valid && ready          status, tokens_left
// cfg_ch    in         valid && ready          index, data (always ready)
//
// a request scans all 64 entries, one table read a cycle
// a sweep skips free entries and runs each valid entry through the multiply and the 18-step divider
// synchronous reset clears the valid map at once, no clearing pass
// a new item is taken while the previous result still waits in the output register
module per_client_token_bucket_limiter import ptbl_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  ptbl_in_if.sink    in_ch,
  ptbl_out_if.source out_ch,
  ptbl_cfg_if.sink   cfg_ch
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_SW_RD  = 8'b0000_1000,
    S_SW_MUL = 8'b0001_0000,
    S_SW_GO  = 8'b0010_0000,
    S_SW_DIV = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0]        limit_r, window_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  entry_t             mem [ENTRIES];
  entry_t             rdata_r;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;

  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               chk_r, chk_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  entry_t             hit_ent_r, hit_ent_nxt;
  logic               free_r, free_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;

  logic [31:0]        key_r;
  logic [47:0]        now_r;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;

  status_t            res_st_r, res_st_nxt;
  logic [15:0]        res_tok_r, res_tok_nxt;
  logic               ov_r, ov_nxt;
  status_t            ost_r, ost_nxt;
  logic [15:0]        otok_r, otok_nxt;

  div_ctl_t           dctl;
  div_sts_t           dsts;
  logic [47:0]        elapsed;
  logic [QUO_W:0]     sum;

  ptbl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dctl),
    .dividend (prod_r),
    .divisor  (den_r),
    .sts      (dsts)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;
  assign out_ch.status = ost_r;
  assign out_ch.tokens_left = otok_r;

  assign elapsed = now_r - rdata_r.last_ms;
  assign sum     = {2'b0, rdata_r.tokens} + (QUO_W+1)'(dsts.quo);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= 16'd10;
      window_r <= 16'd60;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_LIMIT:  limit_r  <= cfg_ch.data;
        REG_WINDOW: window_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    idx_nxt      = idx_r;
    chk_nxt      = 1'b0;
    chk_idx_nxt  = idx_r[IDX_W-1:0];
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_ent_nxt  = hit_ent_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    den_nxt      = den_r;
    prod_nxt     = prod_r;
    res_st_nxt   = res_st_r;
    res_tok_nxt  = res_tok_r;
    ov_nxt       = ov_r;
    ost_nxt      = ost_r;
    otok_nxt     = otok_r;
    we           = 1'b0;
    waddr        = idx_r[IDX_W-1:0];
    wdata        = rdata_r;
    dctl.start   = 1'b0;

    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        idx_nxt  = '0;
        hit_nxt  = 1'b0;
        free_nxt = 1'b0;
        den_nxt  = DEN_W'(((window_r == 16'd0) ? 16'd1 : window_r) * 26'(MS_PER_S));
        if (in_ch.valid) begin
          state_nxt = in_ch.command ? S_SW_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r != CNT_W'(ENTRIES)) begin
          chk_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
        if (chk_r) begin
          if (valid_r[chk_idx_r]) begin
            if (!hit_r && rdata_r.key == key_r) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = chk_idx_r;
              hit_ent_nxt = rdata_r;
            end
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
        end else if (idx_r == CNT_W'(ENTRIES)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_tok_nxt = '0;
        state_nxt   = S_RESULT;
        if (hit_r) begin
          if (hit_ent_r.tokens == '0) begin
            res_st_nxt = ST_TOO_MANY;
          end else begin
            we           = 1'b1;
            waddr        = hit_idx_r;
            wdata        = hit_ent_r;
            wdata.tokens = hit_ent_r.tokens - 1'b1;
            res_st_nxt   = ST_ADMITTED;
            res_tok_nxt  = hit_ent_r.tokens - 1'b1;
          end
        end else if (!free_r) begin
          res_st_nxt = ST_FULL;
        end else begin
          we                    = 1'b1;
          waddr                 = free_idx_r;
          wdata.key             = key_r;
          wdata.last_ms         = now_r;
          valid_nxt[free_idx_r] = 1'b1;
          if (limit_r == '0) begin
            wdata.tokens = '0;
            res_st_nxt   = ST_TOO_MANY;
          end else begin
            wdata.tokens = limit_r - 1'b1;
            res_st_nxt   = ST_ADMITTED;
            res_tok_nxt  = limit_r - 1'b1;
          end
        end
      end
      S_SW_RD: begin
        if (idx_r == CNT_W'(ENTRIES)) begin
          res_st_nxt  = ST_SWEEP;
          res_tok_nxt = '0;
          state_nxt   = S_RESULT;
        end else if (valid_r[idx_r[IDX_W-1:0]]) begin
          state_nxt = S_SW_MUL;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SW_MUL: begin
        prod_nxt  = {16'b0, elapsed} * {48'b0, limit_r};
        state_nxt = S_SW_GO;
      end
      S_SW_GO: begin
        dctl.start = 1'b1;
        state_nxt  = S_SW_DIV;
      end
      S_SW_DIV: begin
        if (dsts.done) begin
          if (dsts.sat || sum >= {2'b0, limit_r}) begin
            if (dsts.sat || dsts.quo != '0) valid_nxt[idx_r[IDX_W-1:0]] = 1'b0;
          end else if (dsts.quo != '0) begin
            we            = 1'b1;
            wdata.tokens  = sum[15:0];
            wdata.last_ms = now_r;
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SW_RD;
        end
      end
      S_RESULT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          ost_nxt   = res_st_r;
          otok_nxt  = res_tok_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      ov_r    <= 1'b0;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      ov_r    <= ov_nxt;
      chk_r   <= chk_nxt;
    end
    if (state_r == S_IDLE && in_ch.valid) begin
      key_r <= in_ch.client_key;
      now_r <= in_ch.now_ms;
    end
    idx_r      <= idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_ent_r  <= hit_ent_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    den_r      <= den_nxt;
    prod_r     <= prod_nxt;
    res_st_r   <= res_st_nxt;
    res_tok_r  <= res_tok_nxt;
    ost_r      <= ost_nxt;
    otok_r     <= otok_nxt;
  end

endmodule
